// File: design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg: types and constants of the descriptor slot allocator
// Holds the command, status, state and register index codes and the fixed
// field widths that the allocator core uses.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // Default number of slots in the descriptor table.
  localparam int DSA_CAPACITY = 1024;

  // Fixed field widths.
  localparam int CMD_W       = 2;
  localparam int SLOT_IDX_W  = 12;
  localparam int STATUS_W    = 3;
  localparam int GRANT_W     = 10;
  localparam int ADDR_W      = 64;
  localparam int STRIDE_W    = 13;
  localparam int OFFSET_W    = STRIDE_W + SLOT_IDX_W - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 144;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_DUP      = 3'd3,
    STATUS_NO_TABLE = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_EN  = 2'd0,
    CFG_CPU_BASE = 2'd1,
    CFG_GPU_BASE = 2'd2,
    CFG_STRIDE   = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

endpackage

// File: design/descriptor_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_core: descriptor table slot allocator
// Allocates slots from a free-list stack or a high-water counter, takes
// slots back with range and duplicate checks, and answers handle queries.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state: in that cycle the stack memory
// (top entry) and the presence bitmap (the addressed slot) are read and the
// stride product is formed. In the execute state that follows, once the
// output register is free or being emptied, the result is decided, the
// memories are written back and the result enters the output register.
// No new request is taken until the sequencer is idle again. The presence
// bitmap holds one bit per slot and is written whenever a slot is issued or
// returned, so every slot below the high-water mark has a defined bit and
// no clearing pass is needed after reset. Configuration writes are always
// accepted and must only be made while no request is in flight.
module descriptor_slot_allocator_core #(
  parameter int CAPACITY = dsa_pkg::DSA_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata fields from bit 0: slot_index[11:0], zero pad[15:12]
  input  logic [dsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser fields from bit 0: cmd[1:0]
  input  logic [dsa_pkg::CMD_W-1:0]        s_axis_tuser_i,
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata fields from bit 0: granted_slot[9:0], cpu_address[73:10],
  // gpu_address[137:74], zero pad[143:138]
  output logic [dsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser fields from bit 0: status[2:0]
  output logic [dsa_pkg::STATUS_W-1:0]     m_axis_tuser_o
);

  import dsa_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int MAG_W  = SLOT_IDX_W - 1;
  localparam int CMP_W  = (CNT_W > MAG_W) ? CNT_W : MAG_W;
  localparam int PAD_W  = OUT_TDATA_W - GRANT_W - 2 * ADDR_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Configuration registers.
  logic                heap_en_q;
  logic [ADDR_W-1:0]   cpu_base_q;
  logic [ADDR_W-1:0]   gpu_base_q;
  logic [STRIDE_W-1:0] stride_q;

  // Allocator state.
  logic [CNT_W-1:0]    high_water_q, high_water_d;
  logic [CNT_W-1:0]    free_count_q, free_count_d;
  fsm_e                state_q, state_d;

  // Request held over the execute cycle.
  cmd_e                cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                in_range_q;
  logic [OFFSET_W-1:0] offset_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [GRANT_W-1:0]  out_grant_q, out_grant_d;
  logic [ADDR_W-1:0]   out_cpu_q, out_cpu_d;
  logic [ADDR_W-1:0]   out_gpu_q, out_gpu_d;

  // Handshake and decode of the incoming request.
  logic                accept;
  logic                commit;
  logic                in_ready;
  logic [SLOT_IDX_W-1:0] in_raw;
  logic [MAG_W-1:0]    in_mag;
  logic                in_range;

  // Memory ports.
  logic                stk_rd_en;
  logic [SLOT_W-1:0]   stk_rd_addr;
  logic [SLOT_W-1:0]   stk_rd_data;
  logic                stk_wr_en;
  logic [SLOT_W-1:0]   stk_wr_addr;
  logic                map_rd_data;
  logic                map_wr_en;
  logic [SLOT_W-1:0]   map_wr_addr;
  logic                map_wr_data;

  // Request decode: an index is in range when not negative and issued.
  assign in_raw   = s_axis_tdata_i[SLOT_IDX_W-1:0];
  assign in_mag   = in_raw[MAG_W-1:0];
  assign in_range = !in_raw[SLOT_IDX_W-1] && (CMP_W'(in_mag) < CMP_W'(high_water_q));
  assign accept   = s_axis_tvalid_i && in_ready;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs: take a request when idle, finish once the output
  // register is free or being emptied.
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_q)
      FSM_IDLE: in_ready = 1'b1;
      FSM_EXEC: commit   = !out_valid_q || m_axis_tready_i;
      default: begin
        in_ready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_en_q  <= 1'b0;
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      stride_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEAP_EN:  heap_en_q  <= cfg_data_i[0];
        CFG_CPU_BASE: cpu_base_q <= cfg_data_i;
        CFG_GPU_BASE: gpu_base_q <= cfg_data_i;
        CFG_STRIDE:   stride_q   <= cfg_data_i[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the request and form the stride product in the accept cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(s_axis_tuser_i);
      slot_q     <= SLOT_W'(in_mag);
      in_range_q <= in_range;
      offset_q   <= OFFSET_W'(stride_q) * OFFSET_W'(in_mag);
    end
  end

  // Memory reads are issued in the accept cycle: top of stack, and the
  // presence bit of the addressed slot.
  assign stk_rd_en   = accept && (free_count_q != '0);
  assign stk_rd_addr = SLOT_W'(free_count_q - CNT_W'(1));

  // Execute: decide the result and the write-back.
  always_comb begin
    high_water_d = high_water_q;
    free_count_d = free_count_q;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;
    out_cpu_d    = out_cpu_q;
    out_gpu_d    = out_gpu_q;
    stk_wr_en    = 1'b0;
    stk_wr_addr  = SLOT_W'(free_count_q);
    map_wr_en    = 1'b0;
    map_wr_addr  = slot_q;
    map_wr_data  = 1'b0;
    if (commit) begin
      out_status_d = STATUS_OK;
      out_grant_d  = '0;
      out_cpu_d    = '0;
      out_gpu_d    = '0;
      case (cmd_q)
        CMD_ALLOC: begin
          if (free_count_q != '0) begin
            // Pop the newest returned slot and clear its presence bit.
            free_count_d = free_count_q - CNT_W'(1);
            out_grant_d  = GRANT_W'(stk_rd_data);
            map_wr_en    = 1'b1;
            map_wr_addr  = stk_rd_data;
          end else if (high_water_q >= CAP_CNT) begin
            out_status_d = STATUS_FULL;
          end else begin
            // Issue a fresh slot and give it a defined presence bit.
            high_water_d = high_water_q + CNT_W'(1);
            out_grant_d  = GRANT_W'(high_water_q);
            map_wr_en    = 1'b1;
            map_wr_addr  = SLOT_W'(high_water_q);
          end
        end
        CMD_FREE: begin
          if (!in_range_q) begin
            out_status_d = STATUS_RANGE;
          end else if (map_rd_data) begin
            out_status_d = STATUS_DUP;
          end else if (free_count_q < CAP_CNT) begin
            // Push the slot and mark it present.
            free_count_d = free_count_q + CNT_W'(1);
            stk_wr_en    = 1'b1;
            map_wr_en    = 1'b1;
            map_wr_data  = 1'b1;
          end
        end
        CMD_QUERY: begin
          if (!heap_en_q) begin
            out_status_d = STATUS_NO_TABLE;
          end else if (!in_range_q) begin
            out_status_d = STATUS_RANGE;
          end else begin
            out_cpu_d = cpu_base_q + ADDR_W'(offset_q);
            out_gpu_d = gpu_base_q + ADDR_W'(offset_q);
          end
        end
        default: out_status_d = STATUS_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_water_q <= '0;
      free_count_q <= '0;
    end else begin
      high_water_q <= high_water_d;
      free_count_q <= free_count_d;
    end
  end

  // Output register: holds a result until it is taken.
  assign out_valid_d = commit || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
    out_cpu_q    <= out_cpu_d;
    out_gpu_q    <= out_gpu_d;
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_gpu_q, out_cpu_q, out_grant_q};

  // Stack and presence bitmap memories.
  dsa_slot_store #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W)
  ) u_store (
    .clk_i         (clk_i),
    .stk_rd_en_i   (stk_rd_en),
    .stk_rd_addr_i (stk_rd_addr),
    .stk_rd_data_o (stk_rd_data),
    .stk_wr_en_i   (stk_wr_en),
    .stk_wr_addr_i (stk_wr_addr),
    .stk_wr_data_i (slot_q),
    .map_rd_en_i   (accept),
    .map_rd_addr_i (SLOT_W'(in_mag)),
    .map_rd_data_o (map_rd_data),
    .map_wr_en_i   (map_wr_en),
    .map_wr_addr_i (map_wr_addr),
    .map_wr_data_i (map_wr_data)
  );

  // The free list never holds more slots than were ever issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= high_water_q)
    else $error("free list larger than the high-water mark");

  // The high-water mark never passes the table capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_water_q <= CAP_CNT)
    else $error("high-water mark beyond capacity");

  // Allocator state only moves when a request completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> (high_water_q == $past(high_water_q)) &&
                (free_count_q == $past(free_count_q)))
    else $error("allocator state changed without a completing request");

  // An accepted request moves the sequencer to execute, and no other is taken while it is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FSM_EXEC) && !s_axis_tready_o)
    else $error("request accepted while another is in flight");

endmodule

// File: design/dsa_slot_store.sv
// ----------------------------------------------------------------------------
// dsa_slot_store: free-list stack and presence bitmap memories
// Two single-port-write synchronous memories with registered reads: the
// stack of returned slot numbers and a one-bit-per-slot presence map.
// ----------------------------------------------------------------------------
module dsa_slot_store #(
  parameter int CAPACITY = 1024,
  parameter int SLOT_W   = $clog2(CAPACITY)
) (
  input  logic              clk_i,
  // Stack read and write ports.
  input  logic              stk_rd_en_i,
  input  logic [SLOT_W-1:0] stk_rd_addr_i,
  output logic [SLOT_W-1:0] stk_rd_data_o,
  input  logic              stk_wr_en_i,
  input  logic [SLOT_W-1:0] stk_wr_addr_i,
  input  logic [SLOT_W-1:0] stk_wr_data_i,
  // Presence bitmap read and write ports.
  input  logic              map_rd_en_i,
  input  logic [SLOT_W-1:0] map_rd_addr_i,
  output logic              map_rd_data_o,
  input  logic              map_wr_en_i,
  input  logic [SLOT_W-1:0] map_wr_addr_i,
  input  logic              map_wr_data_i
);

  logic [SLOT_W-1:0] stk_mem [CAPACITY];
  logic              map_mem [CAPACITY];

  // Stack memory: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (stk_wr_en_i) begin
      stk_mem[stk_wr_addr_i] <= stk_wr_data_i;
    end
    if (stk_rd_en_i) begin
      stk_rd_data_o <= stk_mem[stk_rd_addr_i];
    end
  end

  // Presence bitmap: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (map_wr_en_i) begin
      map_mem[map_wr_addr_i] <= map_wr_data_i;
    end
    if (map_rd_en_i) begin
      map_rd_data_o <= map_mem[map_rd_addr_i];
    end
  end

endmodule
